### rtl/lisl_pkg.sv
// types and constants shared by the segment lookup modules
package lisl_pkg;

   localparam int KEY_W       = 27;
   localparam int SLOPE_W     = 48;
   localparam int ICPT_W      = 64;
   localparam int ERR_W       = 48;
   localparam int COUNT_W     = 32;
   localparam int SEGCNT_W    = 9;
   localparam int SEGIDX_W    = 8;
   localparam int OUT_POS_W   = 32;
   localparam int FRAC_W      = 40;
   localparam int ACC_W       = 84;
   localparam int HALF_W      = 24;
   localparam int PROD_W      = KEY_W + 1 + HALF_W + 1;
   localparam int CSR_INDEX_W = 3;
   localparam int CSR_DATA_W  = 48;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_LOOKUP = 1'b1;

   localparam logic [CSR_INDEX_W-1:0] CSR_MIN_KEY   = 3'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_MAX_KEY   = 3'd1;
   localparam logic [CSR_INDEX_W-1:0] CSR_KEY_COUNT = 3'd2;
   localparam logic [CSR_INDEX_W-1:0] CSR_ERROR     = 3'd3;
   localparam logic [CSR_INDEX_W-1:0] CSR_SEG_COUNT = 3'd4;

   localparam logic [KEY_W-1:0]    MIN_KEY_RESET   = 27'd0;
   localparam logic [KEY_W-1:0]    MAX_KEY_RESET   = 27'd99999999;
   localparam logic [COUNT_W-1:0]  KEY_COUNT_RESET = 32'd0;
   localparam logic [ERR_W-1:0]    ERROR_RESET     = 48'd0;
   localparam logic [SEGCNT_W-1:0] SEG_COUNT_RESET = 9'd2;

   typedef struct packed {
      logic                     command;
      logic [KEY_W-1:0]         key_value;
      logic [SEGIDX_W-1:0]      seg_index;
      logic [KEY_W-1:0]         seg_start_key;
      logic signed [SLOPE_W-1:0] seg_slope;
      logic signed [ICPT_W-1:0]  seg_intercept;
   } req_type;

   typedef struct packed {
      logic [OUT_POS_W-1:0] lower_position;
      logic [OUT_POS_W-1:0] upper_position;
      logic                 out_of_range;
   } rsp_type;

   typedef struct packed {
      logic [KEY_W-1:0]         base_key;
      logic signed [SLOPE_W-1:0] slope;
      logic signed [ICPT_W-1:0]  intercept;
   } seg_entry_type;

   typedef struct packed {
      logic [KEY_W-1:0]    min_key_value;
      logic [KEY_W-1:0]    max_key_value;
      logic [COUNT_W-1:0]  key_count;
      logic [ERR_W-1:0]    error_bound;
      logic [SEGCNT_W-1:0] segment_count;
   } cfg_type;

   typedef struct packed {
      logic load_seg;
      logic start;
      logic step;
      logic fetch;
      logic mul_hi;
      logic accum;
      logic bounds;
      logic load_out;
   } cmd_type;

   typedef struct packed {
      logic out_of_range;
      logic search_done;
   } status_type;

endpackage

### rtl/lisl_ctrl.sv
// sequencer for segment loads and lookups, and the result word's valid flag
module lisl_ctrl import lisl_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic       req_command,
   output logic       req_stall,
   output logic       rsp_valid,
   input  logic       rsp_stall,
   input  status_type status,
   output cmd_type    cmd
);

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_SEARCH,
      ST_FETCH,
      ST_MUL_HI,
      ST_ACCUM,
      ST_BOUNDS,
      ST_CONVERT
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      out_free;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE);
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               if (req_command == CMD_LOOKUP) begin
                  cmd.start = 1'b1;
                  if (status.out_of_range) begin
                     state_in = ST_CONVERT;
                  end else if (status.search_done) begin
                     state_in = ST_FETCH;
                  end else begin
                     state_in = ST_SEARCH;
                  end
               end else begin
                  cmd.load_seg = 1'b1;
               end
            end
         end
         ST_SEARCH: begin
            cmd.step = 1'b1;
            if (status.search_done) begin
               state_in = ST_FETCH;
            end
         end
         ST_FETCH: begin
            cmd.fetch = 1'b1;
            state_in  = ST_MUL_HI;
         end
         ST_MUL_HI: begin
            cmd.mul_hi = 1'b1;
            state_in   = ST_ACCUM;
         end
         ST_ACCUM: begin
            cmd.accum = 1'b1;
            state_in  = ST_BOUNDS;
         end
         ST_BOUNDS: begin
            cmd.bounds = 1'b1;
            state_in   = ST_CONVERT;
         end
         ST_CONVERT: begin
            if (out_free) begin
               cmd.load_out = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // result word stays until taken
   assign rsp_valid_in = cmd.load_out || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

### rtl/lisl_datapath.sv
// segment table, binary search registers, multiply-add and bound conversion
module lisl_datapath import lisl_pkg::*; #(
   parameter int SEGMENT_DEPTH  = 256,
   parameter int POSITION_WIDTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_payload,
   input  cfg_type    cfg,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_payload
);

   localparam int IDX_W = (SEGMENT_DEPTH > 1) ? $clog2(SEGMENT_DEPTH) : 1;
   localparam logic [IDX_W:0] IdxOne = (IDX_W+1)'(1);
   localparam logic [63:0] PosMax = (64'd1 << POSITION_WIDTH) - 64'd1;
   localparam logic signed [ACC_W-1:0] CeilBias = (ACC_W'(1) << FRAC_W) - ACC_W'(1);

   seg_entry_type seg_mem [SEGMENT_DEPTH];
   seg_entry_type rd_ff;

   logic [IDX_W-1:0] left_ff, left_in;
   logic [IDX_W-1:0] right_ff, right_in;
   logic [IDX_W-1:0] mid_ff, mid_in;
   logic [IDX_W-1:0] rd_addr;
   logic [IDX_W:0]   mid_sum;
   logic [IDX_W-1:0] right_init;
   logic [31:0]      seg_cnt;
   logic             seg_in_table;
   logic             key_outside;
   logic             done_in;

   logic [KEY_W-1:0]            key_ff;
   logic                        oor_ff;
   logic signed [HALF_W:0]      slope_hi_ff;
   logic signed [PROD_W-1:0]    prod_ff, prod_in;
   logic signed [KEY_W:0]       mul_a;
   logic signed [HALF_W:0]      mul_b;
   logic signed [ACC_W-1:0]     acc_ff, acc_in;
   logic signed [ACC_W-1:0]     err_al;
   logic signed [ACC_W-1:0]     low_v_ff, high_v_ff;
   rsp_type                     rsp_ff, rsp_in;

   function automatic logic [OUT_POS_W-1:0] to_position(input logic signed [ACC_W-1:0] v,
                                                         input logic up);
      logic signed [ACC_W-1:0] b;
      logic [63:0]             ip;
      logic [OUT_POS_W-1:0]    r;
      b = up ? (v + CeilBias) : v;
      ip = 64'(b[ACC_W-1:FRAC_W]);
      if (v[ACC_W-1] || (v == '0)) begin
         r = '0;
      end else if (ip > PosMax) begin
         r = PosMax[OUT_POS_W-1:0];
      end else begin
         r = ip[OUT_POS_W-1:0];
      end
      return r;
   endfunction

   // segment count clamped to the table, never below two
   always_comb begin
      seg_cnt = 32'(cfg.segment_count);
      if (seg_cnt < 32'd2) begin
         seg_cnt = 32'd2;
      end
      if (seg_cnt > 32'(SEGMENT_DEPTH)) begin
         seg_cnt = 32'(SEGMENT_DEPTH);
      end
   end
   assign right_init = IDX_W'(seg_cnt - 32'd1);

   assign key_outside = (req_payload.key_value < cfg.min_key_value) ||
                        (req_payload.key_value > cfg.max_key_value);
   assign seg_in_table = (32'(req_payload.seg_index) < 32'(SEGMENT_DEPTH));

   // one search step a cycle: next bounds pick the next read address
   always_comb begin
      left_in  = left_ff;
      right_in = right_ff;
      if (cmd.start) begin
         left_in  = '0;
         right_in = right_init;
      end else if (cmd.step) begin
         if (key_ff < rd_ff.base_key) begin
            right_in = mid_ff;
         end else begin
            left_in = mid_ff;
         end
      end
      mid_sum = {1'b0, left_in} + {1'b0, right_in};
      mid_in  = mid_sum[IDX_W:1];
      done_in = (({1'b0, left_in} + IdxOne) == {1'b0, right_in});
      rd_addr = done_in ? left_in : mid_in;
   end

   assign status.out_of_range = key_outside;
   assign status.search_done  = done_in;

   always_ff @(posedge clock) begin
      if (cmd.load_seg && seg_in_table) begin
         seg_mem[IDX_W'(req_payload.seg_index)] <= '{base_key:  req_payload.seg_start_key,
                                                     slope:     req_payload.seg_slope,
                                                     intercept: req_payload.seg_intercept};
      end
      rd_ff <= seg_mem[rd_addr];
   end

   // slope split into a low unsigned half and a high signed half
   assign mul_a   = $signed({1'b0, key_ff});
   assign mul_b   = cmd.fetch ? $signed({1'b0, rd_ff.slope[HALF_W-1:0]}) : slope_hi_ff;
   assign prod_in = mul_a * mul_b;

   assign err_al = $signed({{(ACC_W - ERR_W - HALF_W){1'b0}}, cfg.error_bound,
                            {HALF_W{1'b0}}});

   always_comb begin
      acc_in = acc_ff;
      if (cmd.fetch) begin
         acc_in = ACC_W'(rd_ff.intercept) <<< 16;
      end else if (cmd.mul_hi) begin
         acc_in = acc_ff + ACC_W'(prod_ff);
      end else if (cmd.accum) begin
         acc_in = acc_ff + (ACC_W'(prod_ff) <<< HALF_W);
      end
   end

   always_comb begin
      if (oor_ff) begin
         rsp_in.lower_position = cfg.key_count;
         rsp_in.upper_position = cfg.key_count;
         rsp_in.out_of_range   = 1'b1;
      end else begin
         rsp_in.lower_position = to_position(low_v_ff, 1'b0);
         rsp_in.upper_position = to_position(high_v_ff, 1'b1);
         rsp_in.out_of_range   = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         oor_ff <= 1'b0;
      end else if (cmd.start) begin
         oor_ff <= key_outside;
      end
   end

   always_ff @(posedge clock) begin
      left_ff  <= left_in;
      right_ff <= right_in;
      mid_ff   <= mid_in;
      acc_ff   <= acc_in;
      if (cmd.start) begin
         key_ff <= req_payload.key_value;
      end
      if (cmd.fetch) begin
         slope_hi_ff <= $signed({rd_ff.slope[SLOPE_W-1], rd_ff.slope[SLOPE_W-1:HALF_W]});
      end
      if (cmd.fetch || cmd.mul_hi) begin
         prod_ff <= prod_in;
      end
      if (cmd.bounds) begin
         low_v_ff  <= acc_ff - err_al;
         high_v_ff <= acc_ff + err_al;
      end
      if (cmd.load_out) begin
         rsp_ff <= rsp_in;
      end
   end

   assign rsp_payload = rsp_ff;

endmodule

### rtl/learned_index_segment_lookup.sv
// top level of the piecewise-linear learned index lookup with its csr bank
//
// req channel: a word with command load writes one segment entry (start key,
// slope, intercept) in the cycle it is accepted and gives no result. A word
// with command lookup gives one rsp word with lower and upper positions.
// rsp channel: the result sits in an output register until taken; the block
// may accept the next req word while it waits.
// csr channel: csr_ready is always high; the user must write registers only
// while the block is idle (not enforced). Writes past the list are dropped.
// lookup steps: an out-of-range lookup goes straight to the convert step. An
// in-range lookup does one table read per search step on the single read
// port, then the slope multiply in two halves on one 28 x 25 multiplier,
// the error add and the rounding. req_stall is high for the whole lookup,
// so the block takes no new req word until a lookup is through; while idle
// it takes a load every cycle.
// stall: when rsp_stall holds a finished result, a later lookup waits in
// its last step until the output register frees.
// reset: csr registers return to their defaults and the output empties; the
// segment table holds no defined contents until loaded.
module learned_index_segment_lookup import lisl_pkg::*; #(
   parameter int SEGMENT_DEPTH  = 256,
   parameter int POSITION_WIDTH = 32
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_stall,
   input  req_type                req_payload,
   output logic                   rsp_valid,
   input  logic                   rsp_stall,
   output rsp_type                rsp_payload,
   input  logic                   csr_valid,
   output logic                   csr_ready,
   input  logic [CSR_INDEX_W-1:0] csr_index,
   input  logic [CSR_DATA_W-1:0]  csr_data
);

   cfg_type    cfg_ff, cfg_in;
   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   always_comb begin
      cfg_in = cfg_ff;
      if (csr_valid) begin
         case (csr_index)
            CSR_MIN_KEY:   cfg_in.min_key_value = csr_data[KEY_W-1:0];
            CSR_MAX_KEY:   cfg_in.max_key_value = csr_data[KEY_W-1:0];
            CSR_KEY_COUNT: cfg_in.key_count     = csr_data[COUNT_W-1:0];
            CSR_ERROR:     cfg_in.error_bound   = csr_data[ERR_W-1:0];
            CSR_SEG_COUNT: cfg_in.segment_count = csr_data[SEGCNT_W-1:0];
            default: begin
               cfg_in = cfg_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.min_key_value <= MIN_KEY_RESET;
         cfg_ff.max_key_value <= MAX_KEY_RESET;
         cfg_ff.key_count     <= KEY_COUNT_RESET;
         cfg_ff.error_bound   <= ERROR_RESET;
         cfg_ff.segment_count <= SEG_COUNT_RESET;
      end else begin
         cfg_ff <= cfg_in;
      end
   end

   lisl_ctrl u_ctrl (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_command (req_payload.command),
      .req_stall   (req_stall),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .status      (status),
      .cmd         (cmd)
   );

   lisl_datapath #(
      .SEGMENT_DEPTH  (SEGMENT_DEPTH),
      .POSITION_WIDTH (POSITION_WIDTH)
   ) u_datapath (
      .clock       (clock),
      .reset       (reset),
      .req_payload (req_payload),
      .cfg         (cfg_ff),
      .cmd         (cmd),
      .status      (status),
      .rsp_payload (rsp_payload)
   );

endmodule

### tb/sv/tb_learned_index_segment_lookup.sv
// self-checking testbench for the segment lookup: predicts every lookup word and compares
`timescale 1ns / 1ps

module tb_learned_index_segment_lookup;
   import lisl_pkg::*;

   localparam int TABLE_DEPTH   = 256;
   localparam int SETTLE_CYCLES = 24;
   localparam int RUN_LIMIT_NS  = 5_000_000;

   localparam logic [KEY_W-1:0]          KEY_LIMIT    = 27'd99999999;
   localparam logic signed [SLOPE_W-1:0] SLOPE_TOP    = {1'b0, {(SLOPE_W-1){1'b1}}};
   localparam logic signed [SLOPE_W-1:0] SLOPE_BOTTOM = {1'b1, {(SLOPE_W-1){1'b0}}};
   localparam logic signed [ICPT_W-1:0]  ICPT_TOP     = {1'b0, {(ICPT_W-1){1'b1}}};
   localparam logic signed [ICPT_W-1:0]  ICPT_BOTTOM  = {1'b1, {(ICPT_W-1){1'b0}}};
   localparam logic [CSR_INDEX_W-1:0]    CSR_SPARE_LO = 3'd5;
   localparam logic [CSR_INDEX_W-1:0]    CSR_SPARE_HI = 3'd7;

   // predicts lower/upper positions from its own copy of the table and registers
   class position_checker;
      cfg_type       cfg;
      seg_entry_type seg_tab [TABLE_DEPTH];
      rsp_type       expected_positions [$];
      int            errors;
      int            lookups;
      int            misses;
      int            loads;

      function new();
         cfg = '{MIN_KEY_RESET, MAX_KEY_RESET, KEY_COUNT_RESET, ERROR_RESET, SEG_COUNT_RESET};
         foreach (seg_tab[i]) seg_tab[i] = '0;
         errors  = 0;
         lookups = 0;
         misses  = 0;
         loads   = 0;
      endfunction

      function int used_segments(input int n);
         if (n < 2) return 2;
         if (n > TABLE_DEPTH) return TABLE_DEPTH;
         return n;
      endfunction

      function int pending();
         return expected_positions.size();
      endfunction

      function void write_reg(input logic [CSR_INDEX_W-1:0] idx,
                              input logic [CSR_DATA_W-1:0] d);
         case (idx)
            CSR_MIN_KEY:   cfg.min_key_value = d[KEY_W-1:0];
            CSR_MAX_KEY:   cfg.max_key_value = d[KEY_W-1:0];
            CSR_KEY_COUNT: cfg.key_count     = d[COUNT_W-1:0];
            CSR_ERROR:     cfg.error_bound   = d[ERR_W-1:0];
            CSR_SEG_COUNT: cfg.segment_count = d[SEGCNT_W-1:0];
            default: ;
         endcase
      endfunction

      // positive fixed-point value with 40 fraction bits to a saturated position
      function logic [OUT_POS_W-1:0] to_position(input logic signed [127:0] v,
                                                 input bit round_up);
         logic signed [127:0] q;
         if (v <= 0) return '0;
         q = round_up ? v + ((128'sd1 <<< FRAC_W) - 128'sd1) : v;
         q = q >>> FRAC_W;
         if (q[127:OUT_POS_W] != '0) return '1;
         return q[OUT_POS_W-1:0];
      endfunction

      function rsp_type predict_positions(input logic [KEY_W-1:0] key);
         rsp_type             r;
         int                  n, lo, hi, mid;
         logic signed [127:0] k, s, ic, e, acc;
         r = '0;
         if (key < cfg.min_key_value || key > cfg.max_key_value) begin
            r.lower_position = cfg.key_count;
            r.upper_position = cfg.key_count;
            r.out_of_range   = 1'b1;
            return r;
         end
         n  = used_segments(int'(cfg.segment_count));
         lo = 0;
         hi = n - 1;
         // last entry only bounds the search
         while (lo != hi - 1) begin
            mid = (lo + hi) / 2;
            if (key < seg_tab[mid].base_key) hi = mid;
            else lo = mid;
         end
         k   = {101'd0, key};
         s   = {{(128-SLOPE_W){seg_tab[lo].slope[SLOPE_W-1]}}, seg_tab[lo].slope};
         ic  = {{(128-ICPT_W){seg_tab[lo].intercept[ICPT_W-1]}}, seg_tab[lo].intercept};
         ic  = ic <<< 16;
         e   = {80'd0, cfg.error_bound};
         e   = e <<< 24;
         acc = k * s + ic;
         r.lower_position = to_position(acc - e, 1'b0);
         r.upper_position = to_position(acc + e, 1'b1);
         return r;
      endfunction

      function void note_word(input req_type w);
         rsp_type want;
         if (w.command == CMD_LOAD) begin
            seg_tab[w.seg_index].base_key  = w.seg_start_key;
            seg_tab[w.seg_index].slope     = w.seg_slope;
            seg_tab[w.seg_index].intercept = w.seg_intercept;
            loads++;
         end else begin
            want = predict_positions(w.key_value);
            expected_positions = {expected_positions, want};
            lookups++;
            if (want.out_of_range) misses++;
         end
      endfunction

      task report(input string msg);
         errors++;
         $display("mismatch at %0t: %s", $realtime, msg);
      endtask

      task check_positions(input rsp_type got);
         rsp_type want;
         if (expected_positions.size() == 0) begin
            report("result word with no lookup waiting");
            return;
         end
         want = expected_positions.pop_front();
         if (got.lower_position !== want.lower_position)
            report($sformatf("lower_position got %h want %h",
                             got.lower_position, want.lower_position));
         if (got.upper_position !== want.upper_position)
            report($sformatf("upper_position got %h want %h",
                             got.upper_position, want.upper_position));
         if (got.out_of_range !== want.out_of_range)
            report($sformatf("out_of_range got %b want %b",
                             got.out_of_range, want.out_of_range));
      endtask
   endclass

   logic                   clock       = 1'b0;
   logic                   reset       = 1'b1;
   logic                   req_valid   = 1'b0;
   logic                   req_stall;
   req_type                req_payload = '0;
   logic                   rsp_valid;
   logic                   rsp_stall   = 1'b0;
   rsp_type                rsp_payload;
   logic                   csr_valid   = 1'b0;
   logic                   csr_ready;
   logic [CSR_INDEX_W-1:0] csr_index   = '0;
   logic [CSR_DATA_W-1:0]  csr_data    = '0;

   bit              no_idle       = 1'b0;
   int              settings_done = 0;
   position_checker pos_chk;

   learned_index_segment_lookup i_dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_stall   (req_stall),
      .req_payload (req_payload),
      .rsp_valid   (rsp_valid),
      .rsp_stall   (rsp_stall),
      .rsp_payload (rsp_payload),
      .csr_valid   (csr_valid),
      .csr_ready   (csr_ready),
      .csr_index   (csr_index),
      .csr_data    (csr_data)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   initial begin
      #(RUN_LIMIT_NS);
      $display("simulation failed");
      $finish;
   end

   always @(posedge clock) begin
      if (!reset && rsp_valid && !rsp_stall) pos_chk.check_positions(rsp_payload);
   end

   // result side: random hold-off before each word is taken
   initial begin : rsp_side
      int gap;
      wait (reset == 1'b0);
      @(negedge clock);
      forever begin
         gap = no_idle ? 0 : $urandom_range(0, 16);
         if (gap > 0) begin
            rsp_stall = 1'b1;
            repeat (gap) @(negedge clock);
         end
         rsp_stall = 1'b0;
         do @(posedge clock); while (!rsp_valid);
         @(negedge clock);
      end
   end

   task automatic send_word(input req_type w);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 16);
      if (gap > 0) begin
         req_valid = 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_payload = w;
      req_valid   = 1'b1;
      do @(posedge clock); while (req_stall);
      pos_chk.note_word(w);
      @(negedge clock);
   endtask

   task automatic csr_write(input logic [CSR_INDEX_W-1:0] idx,
                            input logic [CSR_DATA_W-1:0] d);
      csr_valid = 1'b1;
      csr_index = idx;
      csr_data  = d;
      do @(posedge clock); while (!csr_ready);
      pos_chk.write_reg(idx, d);
      @(negedge clock);
   endtask

   // loads give no result word, so allow the pipe to drain before touching csrs
   task automatic wait_idle();
      req_valid = 1'b0;
      while (pos_chk.pending() != 0) @(negedge clock);
      repeat (SETTLE_CYCLES) @(negedge clock);
   endtask

   task automatic apply_config(input cfg_type c);
      wait_idle();
      csr_write(CSR_MIN_KEY,   CSR_DATA_W'(c.min_key_value));
      csr_write(CSR_MAX_KEY,   CSR_DATA_W'(c.max_key_value));
      csr_write(CSR_KEY_COUNT, CSR_DATA_W'(c.key_count));
      csr_write(CSR_ERROR,     CSR_DATA_W'(c.error_bound));
      csr_write(CSR_SEG_COUNT, CSR_DATA_W'(c.segment_count));
      csr_valid = 1'b0;
      settings_done++;
   endtask

   function automatic cfg_type make_cfg(input logic [KEY_W-1:0] lo, input logic [KEY_W-1:0] hi,
                                        input logic [COUNT_W-1:0] cnt,
                                        input logic [ERR_W-1:0] err,
                                        input logic [SEGCNT_W-1:0] segs);
      cfg_type c;
      c.min_key_value = lo;
      c.max_key_value = hi;
      c.key_count     = cnt;
      c.error_bound   = err;
      c.segment_count = segs;
      return c;
   endfunction

   function automatic req_type lookup_word(input logic [KEY_W-1:0] key);
      req_type w;
      w.command       = CMD_LOOKUP;
      w.key_value     = key;
      w.seg_index     = SEGIDX_W'($urandom);
      w.seg_start_key = KEY_W'($urandom);
      w.seg_slope     = SLOPE_W'({$urandom, $urandom});
      w.seg_intercept = {$urandom, $urandom};
      return w;
   endfunction

   function automatic req_type load_word(input int idx, input logic [KEY_W-1:0] sk,
                                         input logic signed [SLOPE_W-1:0] sl,
                                         input logic signed [ICPT_W-1:0] ic);
      req_type w;
      w.command       = CMD_LOAD;
      w.key_value     = KEY_W'($urandom);
      w.seg_index     = SEGIDX_W'(idx);
      w.seg_start_key = sk;
      w.seg_slope     = sl;
      w.seg_intercept = ic;
      return w;
   endfunction

   // mostly segments that land near a chosen position at their start key
   task automatic pick_segment(input logic [KEY_W-1:0] sk,
                               output logic signed [SLOPE_W-1:0] sl,
                               output logic signed [ICPT_W-1:0] ic);
      logic [31:0]         pos;
      logic signed [127:0] t;
      if ($urandom_range(0, 9) < 7) begin
         sl = SLOPE_W'($urandom_range(0, 32'h7FFF_FFFF)) << $urandom_range(0, 10);
         if ($urandom_range(0, 3) == 0) sl = -sl;
         pos = $urandom;
         t   = $signed({96'd0, pos}) <<< FRAC_W;
         t   = t - $signed({101'd0, sk}) * $signed({{(128-SLOPE_W){sl[SLOPE_W-1]}}, sl});
         ic  = t[ICPT_W+15:16];
      end else begin
         sl = SLOPE_W'({$urandom, $urandom});
         sl = sl >>> $urandom_range(0, SLOPE_W - 1);
         ic = {$urandom, $urandom};
         ic = ic >>> $urandom_range(0, ICPT_W - 1);
      end
   endtask

   // sorted start keys across the whole key space, entry 0 at key 0
   task automatic build_table(input int n_used);
      int                        step;
      logic [KEY_W-1:0]          sk;
      logic signed [SLOPE_W-1:0] sl;
      logic signed [ICPT_W-1:0]  ic;
      step = 100000000 / n_used;
      for (int i = 0; i < n_used; i++) begin
         sk = (i == 0) ? '0 : KEY_W'(i * step + $urandom_range(0, step - 1));
         pick_segment(sk, sl, ic);
         send_word(load_word(i, sk, sl, ic));
      end
   endtask

   function automatic logic [KEY_W-1:0] pick_key(input int n_used);
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 10) return KEY_W'($urandom_range(0, 99999999));
      if (r < 15 && pos_chk.cfg.min_key_value != 0)
         return pos_chk.cfg.min_key_value - 1'b1;
      if (r < 20 && pos_chk.cfg.max_key_value < KEY_LIMIT)
         return pos_chk.cfg.max_key_value + 1'b1;
      if (r < 50) begin
         // either side of a segment boundary
         v = int'(pos_chk.seg_tab[$urandom_range(0, n_used - 1)].base_key);
         v = v - 1 + $urandom_range(0, 2);
         if (v < 0) v = 0;
         if (v > 99999999) v = 99999999;
         return KEY_W'(v);
      end
      if (pos_chk.cfg.min_key_value > pos_chk.cfg.max_key_value)
         return KEY_W'($urandom_range(0, 99999999));
      return pos_chk.cfg.min_key_value + KEY_W'($urandom_range(0,
             pos_chk.cfg.max_key_value - pos_chk.cfg.min_key_value));
   endfunction

   task automatic random_item(input int n_used);
      logic signed [SLOPE_W-1:0] sl;
      logic signed [ICPT_W-1:0]  ic;
      logic [KEY_W-1:0]          sk;
      if ($urandom_range(0, 99) < 12) begin
         sk = KEY_W'($urandom_range(0, 99999999));
         pick_segment(sk, sl, ic);
         send_word(load_word($urandom_range(0, TABLE_DEPTH - 1), sk, sl, ic));
      end else begin
         send_word(lookup_word(pick_key(n_used)));
      end
   endtask

   initial begin : stimulus
      cfg_type c;
      int      seg_list [12];
      int      n_used;
      pos_chk  = new();
      seg_list = '{2, 3, 4, 7, 16, 256, 0, 1, 511, 33, 5, 256};
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset = 1'b0;

      build_table(TABLE_DEPTH);

      // directed: register defaults, key extremes
      send_word(lookup_word('0));
      send_word(lookup_word(KEY_LIMIT));
      send_word(lookup_word(pos_chk.seg_tab[1].base_key));

      apply_config(make_cfg(27'd1000, 27'd99000000, '1, '0, 9'd256));
      send_word(lookup_word(27'd999));
      send_word(lookup_word(27'd99000001));
      send_word(lookup_word(27'd1000));
      send_word(lookup_word(27'd99000000));
      send_word(lookup_word(pos_chk.seg_tab[128].base_key));
      send_word(lookup_word(pos_chk.seg_tab[128].base_key - 1'b1));

      // writes past the register list must change nothing
      wait_idle();
      csr_write(CSR_SPARE_LO, CSR_DATA_W'({$urandom, $urandom}));
      csr_write(CSR_SPARE_HI, CSR_DATA_W'({$urandom, $urandom}));
      csr_valid = 1'b0;
      send_word(lookup_word(27'd5000));

      // min above max, segment count of zero
      apply_config(make_cfg(27'd5000, 27'd4000, 32'd123, '1, 9'd0));
      send_word(lookup_word(27'd4500));
      send_word(lookup_word('0));
      send_word(lookup_word(KEY_LIMIT));

      // one segment in use: saturation, negative results and rounding
      apply_config(make_cfg('0, KEY_LIMIT, '0, '0, 9'd1));
      send_word(load_word(0, '0, SLOPE_TOP, ICPT_TOP));
      send_word(lookup_word(KEY_LIMIT));
      send_word(load_word(0, '0, SLOPE_BOTTOM, ICPT_BOTTOM));
      send_word(lookup_word(KEY_LIMIT));
      send_word(load_word(0, '0, '0, (64'sd5 <<< 24) + 64'sd1));
      send_word(lookup_word(27'd7));
      send_word(load_word(0, '0, -48'sd1, '0));
      send_word(lookup_word(27'd1));

      // largest error and a segment count past the table
      apply_config(make_cfg('0, KEY_LIMIT, '0, '1, 9'd511));
      send_word(lookup_word('0));
      send_word(lookup_word(KEY_LIMIT));

      for (int p = 0; p < 12; p++) begin
         if (p == 6) begin
            c.min_key_value = KEY_W'(70000000 + $urandom_range(0, 29999999));
            c.max_key_value = KEY_W'($urandom_range(0, 69999999));
         end else begin
            c.min_key_value = ($urandom_range(0, 3) == 0) ? '0 :
                              KEY_W'($urandom_range(0, 60000000));
            c.max_key_value = ($urandom_range(0, 3) == 0) ? KEY_LIMIT :
                              KEY_W'($urandom_range(c.min_key_value, 99999999));
         end
         c.key_count     = $urandom;
         c.error_bound   = ERR_W'({$urandom, $urandom}) >> $urandom_range(0, ERR_W);
         c.segment_count = SEGCNT_W'(seg_list[p]);
         apply_config(c);
         n_used  = pos_chk.used_segments(seg_list[p]);
         no_idle = (p % 4 == 1);
         // full-size settings reuse the table already in place
         if (n_used < TABLE_DEPTH) begin
            build_table(n_used);
         end
         repeat (37) random_item(n_used);
      end

      no_idle = 1'b0;
      wait_idle();
      $display("covered %0d lookups (%0d out of range) and %0d table loads over %0d settings",
               pos_chk.lookups, pos_chk.misses, pos_chk.loads, settings_done);
      if (pos_chk.errors == 0 && pos_chk.pending() == 0) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end

endmodule
